// ===== design/sdpa_pkg.sv =====
// Package for the step/pulse drift accounting block: widths, request codes,
// sequencer states and the structs passed between the store and the sequencer.
// No dependencies.
package sdpa_pkg;

    localparam int MAX_MOTORS = 8;
    localparam int IDX_W      = $clog2(MAX_MOTORS);
    localparam int CNT_W      = $clog2(MAX_MOTORS + 1);
    localparam int CFG_W      = 4;
    localparam int TOT_W      = 35;
    localparam int MASK_W     = 8;
    localparam int ACNT_W     = 4;

    // Request kinds carried in the input tuser
    localparam logic [2:0] REQ_RESET = 3'd0;
    localparam logic [2:0] REQ_BEGIN = 3'd1;
    localparam logic [2:0] REQ_END   = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_STEPS = 3'd4;
    localparam logic [2:0] REQ_STATS = 3'd5;

    localparam logic [CFG_W-1:0] CHAN_LIMIT_RST = CFG_W'(MAX_MOTORS);

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_NEG
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_DELTA,
        ST_RD_ABS,
        ST_RD_CNT,
        ST_RD_POS,
        ST_SP_CNT,
        ST_SP_POS,
        ST_Q_DIFF,
        ST_Q_ABS,
        ST_Q_PDR,
        ST_Q_ITOT,
        ST_Q_MTOT,
        ST_Q_FIN,
        ST_Q_DRIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [2:0]         motor_index;
        logic signed [31:0] ctr_value;
        logic               read_error;
        logic [31:0]        step_count;
        logic               step_direction;
    } req_t;

    typedef struct packed {
        logic [TOT_W-1:0]  cmd_steps_sum;
        logic [TOT_W-1:0]  pulse_sum;
        logic [TOT_W-1:0]  count_drift_total;
        logic [31:0]       pos_drift_sum;
        logic [MASK_W-1:0] faulty_bits;
        logic [MASK_W-1:0] moving_bits;
        logic [ACNT_W-1:0] active_count;
        logic              session_running;
        logic              session_has_data;
    } res_t;

    // One channel entry as read from the store
    typedef struct packed {
        logic [31:0] last_raw;
        logic [31:0] meas_steps;
        logic [63:0] meas_pos;
        logic [31:0] inf_steps;
        logic [63:0] inf_pos;
        logic        unrel;
    } ch_entry_t;

    // Write command into the store; cnt and pos serve whichever count or
    // position is written in that cycle
    typedef struct packed {
        logic             clear;
        logic [IDX_W-1:0] idx;
        logic             we_raw;
        logic             we_meas_steps;
        logic             we_meas_pos;
        logic             we_inf_steps;
        logic             we_inf_pos;
        logic             we_unrel;
        logic [31:0]      raw;
        logic [31:0]      cnt;
        logic [63:0]      pos;
    } st_wr_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

// ===== design/sdpa_alu.sv =====
// Shared 64-bit add / subtract / negate unit for the drift accounting block.
// Depends on sdpa_pkg.
module sdpa_alu (
    input  sdpa_pkg::alu_op_t op,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic [63:0]       y
);
    import sdpa_pkg::*;

    logic [63:0] opa;
    logic [63:0] opb;
    logic        cin;

    always_comb begin
        opa = a;
        opb = b;
        cin = 1'b0;
        case (op)
            ALU_ADD: begin
                opb = b;
                cin = 1'b0;
            end
            ALU_SUB: begin
                opb = ~b;
                cin = 1'b1;
            end
            ALU_NEG: begin
                opa = ~a;
                opb = 64'd0;
                cin = 1'b1;
            end
            default: begin
                opb = b;
                cin = 1'b0;
            end
        endcase
    end

    assign y = opa + opb + {63'd0, cin};

endmodule

// ===== design/sdpa_store.sv =====
// Per-channel register file: counts, positions, last raw reading, unreliable
// flags. One read port, one write port, clear of every entry at once. Depends on sdpa_pkg.
module sdpa_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sdpa_pkg::IDX_W-1:0] rd_idx,
    output sdpa_pkg::ch_entry_t        rd_entry,
    input  sdpa_pkg::st_wr_t           wr
);
    import sdpa_pkg::*;

    logic [31:0] last_raw_reg   [MAX_MOTORS];
    logic [31:0] meas_steps_reg [MAX_MOTORS];
    logic [63:0] meas_pos_reg   [MAX_MOTORS];
    logic [31:0] inf_steps_reg  [MAX_MOTORS];
    logic [63:0] inf_pos_reg    [MAX_MOTORS];
    logic        unrel_reg      [MAX_MOTORS];

    always_ff @(posedge aclk) begin
        if (!aresetn || wr.clear) begin
            for (int i = 0; i < MAX_MOTORS; i++) begin
                last_raw_reg[i]   <= 32'd0;
                meas_steps_reg[i] <= 32'd0;
                meas_pos_reg[i]   <= 64'd0;
                inf_steps_reg[i]  <= 32'd0;
                inf_pos_reg[i]    <= 64'd0;
                unrel_reg[i]      <= 1'b0;
            end
        end else begin
            if (wr.we_raw)        last_raw_reg[wr.idx]   <= wr.raw;
            if (wr.we_meas_steps) meas_steps_reg[wr.idx] <= wr.cnt;
            if (wr.we_meas_pos)   meas_pos_reg[wr.idx]   <= wr.pos;
            if (wr.we_inf_steps)  inf_steps_reg[wr.idx]  <= wr.cnt;
            if (wr.we_inf_pos)    inf_pos_reg[wr.idx]    <= wr.pos;
            if (wr.we_unrel)      unrel_reg[wr.idx]      <= 1'b1;
        end
    end

    always_comb begin
        rd_entry.last_raw   = last_raw_reg[rd_idx];
        rd_entry.meas_steps = meas_steps_reg[rd_idx];
        rd_entry.meas_pos   = meas_pos_reg[rd_idx];
        rd_entry.inf_steps  = inf_steps_reg[rd_idx];
        rd_entry.inf_pos    = inf_pos_reg[rd_idx];
        rd_entry.unrel      = unrel_reg[rd_idx];
    end

endmodule

// ===== design/sdpa_seq.sv =====
// Sequencer for the drift accounting block: steps the shared ALU through each
// request, walks the channels for a stats query, holds session flags and the
// result register. Depends on sdpa_pkg and sdpa_alu.
module sdpa_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sdpa_pkg::req_t             in_req,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sdpa_pkg::res_t             out_res,
    input  logic [sdpa_pkg::CFG_W-1:0] chan_limit,
    output logic [sdpa_pkg::IDX_W-1:0] rd_idx,
    input  sdpa_pkg::ch_entry_t        rd_entry,
    output sdpa_pkg::st_wr_t           wr
);
    import sdpa_pkg::*;

    state_t             state_reg,    state_next;
    req_t               req_reg,      req_next;
    logic [IDX_W-1:0]   idx_reg,      idx_next;
    logic [63:0]        t_reg,        t_next;
    logic [63:0]        m_reg,        m_next;
    logic [TOT_W-1:0]   itot_reg,     itot_next;
    logic [TOT_W-1:0]   mtot_reg,     mtot_next;
    logic [TOT_W-1:0]   cd_reg,       cd_next;
    logic [31:0]        pdr_reg,      pdr_next;
    logic [MASK_W-1:0]  umask_reg,    umask_next;
    logic [MASK_W-1:0]  amask_reg,    amask_next;
    logic [ACNT_W-1:0]  acnt_reg,     acnt_next;
    logic               sess_reg,     sess_next;
    logic               has_reg,      has_next;
    res_t               res_reg,      res_next;
    logic               ovalid_reg,   ovalid_next;

    alu_op_t            alu_op;
    logic [63:0]        alu_a;
    logic [63:0]        alu_b;
    logic [63:0]        alu_y;

    logic [CNT_W-1:0]   n_chan;
    logic               in_range;
    logic               last_ch;
    logic               ch_active;
    logic [63:0]        mag;

    sdpa_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign n_chan    = (chan_limit > CFG_W'(MAX_MOTORS)) ? CNT_W'(MAX_MOTORS)
                                                         : CNT_W'(chan_limit);
    assign in_range  = CNT_W'(req_reg.motor_index) < n_chan;
    assign last_ch   = CNT_W'(idx_reg) == (n_chan - CNT_W'(1));
    assign ch_active = (rd_entry.meas_steps != 32'd0) || (rd_entry.inf_steps != 32'd0) ||
                       (rd_entry.meas_pos != 64'd0) || (rd_entry.inf_pos != 64'd0);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;
    assign rd_idx    = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sess_reg   <= 1'b0;
            has_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sess_reg   <= sess_next;
            has_reg    <= has_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        t_reg     <= t_next;
        m_reg     <= m_next;
        itot_reg  <= itot_next;
        mtot_reg  <= mtot_next;
        cd_reg    <= cd_next;
        pdr_reg   <= pdr_next;
        umask_reg <= umask_next;
        amask_reg <= amask_next;
        acnt_reg  <= acnt_next;
        res_reg   <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        t_next      = t_reg;
        m_next      = m_reg;
        itot_next   = itot_reg;
        mtot_next   = mtot_reg;
        cd_next     = cd_reg;
        pdr_next    = pdr_reg;
        umask_next  = umask_reg;
        amask_next  = amask_reg;
        acnt_next   = acnt_reg;
        sess_next   = sess_reg;
        has_next    = has_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !out_ready;

        alu_op = ALU_ADD;
        alu_a  = 64'd0;
        alu_b  = 64'd0;
        mag    = t_reg;

        wr     = '0;
        wr.idx = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    idx_next   = in_req.motor_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_DONE;
                case (req_reg.req_type)
                    REQ_RESET: begin
                        wr.clear  = 1'b1;
                        sess_next = 1'b0;
                        has_next  = 1'b0;
                    end
                    REQ_BEGIN: begin
                        wr.clear  = 1'b1;
                        sess_next = 1'b1;
                        has_next  = 1'b1;
                    end
                    REQ_END: begin
                        sess_next = 1'b0;
                    end
                    REQ_READ: begin
                        if (sess_reg && in_range) begin
                            if (req_reg.read_error) begin
                                wr.we_unrel = 1'b1;
                            end else begin
                                state_next = ST_RD_DELTA;
                            end
                        end
                    end
                    REQ_STEPS: begin
                        if (in_range && req_reg.step_count != 32'd0) begin
                            state_next = ST_SP_CNT;
                        end
                    end
                    REQ_STATS: begin
                        idx_next   = '0;
                        itot_next  = '0;
                        mtot_next  = '0;
                        pdr_next   = '0;
                        umask_next = '0;
                        amask_next = '0;
                        acnt_next  = '0;
                        state_next = (n_chan == CNT_W'(0)) ? ST_Q_FIN : ST_Q_DIFF;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // signed delta of the new raw reading against the last one
            ST_RD_DELTA: begin
                alu_op     = ALU_SUB;
                alu_a      = {{32{req_reg.ctr_value[31]}}, req_reg.ctr_value};
                alu_b      = {{32{rd_entry.last_raw[31]}}, rd_entry.last_raw};
                t_next     = alu_y;
                state_next = ST_RD_ABS;
            end

            ST_RD_ABS: begin
                alu_op     = ALU_NEG;
                alu_a      = t_reg;
                m_next     = t_reg[63] ? alu_y : t_reg;
                state_next = ST_RD_CNT;
            end

            ST_RD_CNT: begin
                alu_op           = ALU_ADD;
                alu_a            = {32'd0, rd_entry.meas_steps};
                alu_b            = m_reg;
                wr.we_meas_steps = 1'b1;
                wr.cnt           = sat32(alu_y);
                state_next       = ST_RD_POS;
            end

            ST_RD_POS: begin
                alu_op         = ALU_ADD;
                alu_a          = rd_entry.meas_pos;
                alu_b          = t_reg;
                wr.we_meas_pos = 1'b1;
                wr.pos         = alu_y;
                wr.we_raw      = 1'b1;
                wr.raw         = req_reg.ctr_value;
                state_next     = ST_DONE;
            end

            ST_SP_CNT: begin
                alu_op          = ALU_ADD;
                alu_a           = {32'd0, rd_entry.inf_steps};
                alu_b           = {32'd0, req_reg.step_count};
                wr.we_inf_steps = 1'b1;
                wr.cnt          = sat32(alu_y);
                state_next      = ST_SP_POS;
            end

            ST_SP_POS: begin
                alu_op        = req_reg.step_direction ? ALU_SUB : ALU_ADD;
                alu_a         = rd_entry.inf_pos;
                alu_b         = {32'd0, req_reg.step_count};
                wr.we_inf_pos = 1'b1;
                wr.pos        = alu_y;
                state_next    = ST_DONE;
            end

            // position difference; masks taken from the same read
            ST_Q_DIFF: begin
                alu_op              = ALU_SUB;
                alu_a               = rd_entry.inf_pos;
                alu_b               = rd_entry.meas_pos;
                t_next              = alu_y;
                umask_next[idx_reg] = rd_entry.unrel;
                amask_next[idx_reg] = ch_active;
                if (ch_active) begin
                    acnt_next = acnt_reg + ACNT_W'(1);
                end
                state_next = ST_Q_ABS;
            end

            ST_Q_ABS: begin
                alu_op     = ALU_NEG;
                alu_a      = t_reg;
                mag        = t_reg[63] ? alu_y : t_reg;
                m_next     = {32'd0, sat32(mag)};
                state_next = ST_Q_PDR;
            end

            ST_Q_PDR: begin
                alu_op     = ALU_ADD;
                alu_a      = {32'd0, pdr_reg};
                alu_b      = m_reg;
                pdr_next   = sat32(alu_y);
                state_next = ST_Q_ITOT;
            end

            ST_Q_ITOT: begin
                alu_op     = ALU_ADD;
                alu_a      = {29'd0, itot_reg};
                alu_b      = {32'd0, rd_entry.inf_steps};
                itot_next  = alu_y[TOT_W-1:0];
                state_next = ST_Q_MTOT;
            end

            ST_Q_MTOT: begin
                alu_op    = ALU_ADD;
                alu_a     = {29'd0, mtot_reg};
                alu_b     = {32'd0, rd_entry.meas_steps};
                mtot_next = alu_y[TOT_W-1:0];
                if (last_ch) begin
                    state_next = ST_Q_FIN;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_Q_DIFF;
                end
            end

            ST_Q_FIN: begin
                alu_op     = ALU_SUB;
                alu_a      = {29'd0, itot_reg};
                alu_b      = {29'd0, mtot_reg};
                t_next     = alu_y;
                state_next = ST_Q_DRIFT;
            end

            ST_Q_DRIFT: begin
                alu_op     = ALU_NEG;
                alu_a      = t_reg;
                cd_next    = t_reg[63] ? alu_y[TOT_W-1:0] : t_reg[TOT_W-1:0];
                state_next = ST_DONE;
            end

            // hold until the result register is free
            ST_DONE: begin
                if (!ovalid_reg || out_ready) begin
                    res_next = '0;
                    if (req_reg.req_type == REQ_STATS) begin
                        res_next.cmd_steps_sum     = itot_reg;
                        res_next.pulse_sum         = mtot_reg;
                        res_next.count_drift_total = cd_reg;
                        res_next.pos_drift_sum     = pdr_reg;
                        res_next.faulty_bits       = umask_reg;
                        res_next.moving_bits       = amask_reg;
                        res_next.active_count      = acnt_reg;
                    end
                    res_next.session_running  = sess_reg;
                    res_next.session_has_data = has_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/step_pulse_drift_accounting_top.sv =====
// Top level of the step/pulse drift accounting block: stream ports, the
// channel-limit register, channel store and sequencer.
// Depends on sdpa_pkg, sdpa_store, sdpa_seq (and sdpa_alu through sdpa_seq).
//
// Keeps per-motor accounting of commanded steps against counted pulses for up
// to eight channels. Every input word yields exactly one result word. Items
// are handled one at a time by a sequencer that drives a single shared 64-bit
// add/subtract/negate unit; s_tready is high only while the sequencer is idle.
// After acceptance, reset, begin, end and unknown kinds go through the execute
// and done states only; an emitted-steps record adds a count and a position
// update (skipped when out of range or zero steps), a counter reading a delta,
// magnitude, count and position update (skipped when ignored or on a read
// error), and a stats query five passes through the shared unit per configured
// channel and a final subtract and negate. s_tready rises in the same cycle as
// m_tvalid, when the result is loaded. The result sits in an output register,
// so a new word is taken while the previous result still waits for m_tready.
// Write the channel-limit register only while the block is idle.
module step_pulse_drift_accounting_top (
    input  logic                       aclk,
    input  logic                       aresetn,

    // Configuration: number of channels in use
    input  logic                       cfg_wr_en,
    input  logic [sdpa_pkg::CFG_W-1:0] cfg_wr_data,

    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [2:0] motor_index, [34:3] ctr_value, [35] read_error,
    // [67:36] step_count, [68] step_direction, [71:69] zero
    input  logic [71:0]                s_tdata,
    // [2:0] req_type
    input  logic [2:0]                 s_tuser,

    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [34:0] cmd_steps_sum, [69:35] pulse_sum,
    // [104:70] count_drift_total, [136:105] pos_drift_sum,
    // [144:137] faulty_bits, [152:145] moving_bits,
    // [156:153] active_count, [157] session_running,
    // [158] session_has_data, [159] zero
    output logic [159:0]               m_tdata
);
    import sdpa_pkg::*;

    logic [CFG_W-1:0] chan_limit_reg;
    req_t             in_req;
    res_t             res;
    logic [IDX_W-1:0] rd_idx;
    ch_entry_t        rd_entry;
    st_wr_t           st_wr;

    // Channel-limit register: write-only, taken whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_limit_reg <= CHAN_LIMIT_RST;
        end else if (cfg_wr_en) begin
            chan_limit_reg <= cfg_wr_data;
        end
    end

    // Unpack the input word
    always_comb begin
        in_req.req_type       = s_tuser;
        in_req.motor_index    = s_tdata[2:0];
        in_req.ctr_value      = s_tdata[34:3];
        in_req.read_error     = s_tdata[35];
        in_req.step_count     = s_tdata[67:36];
        in_req.step_direction = s_tdata[68];
    end

    // Channel store: single read port addressed by the sequencer
    sdpa_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr       (st_wr)
    );

    // Sequencer with the shared arithmetic unit and result register
    sdpa_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (in_req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .chan_limit  (chan_limit_reg),
        .rd_idx      (rd_idx),
        .rd_entry    (rd_entry),
        .wr          (st_wr)
    );

    // Pack the result word, lowest field first, pad to whole bytes
    assign m_tdata = {1'b0,
                      res.session_has_data,
                      res.session_running,
                      res.active_count,
                      res.moving_bits,
                      res.faulty_bits,
                      res.pos_drift_sum,
                      res.count_drift_total,
                      res.pulse_sum,
                      res.cmd_steps_sum};

endmodule
